/* src/pol_pkg.sv */
// Package for the palette overlay luma blend: word types, register indexes and constants.
`timescale 1ns / 1ps
`default_nettype none
package pol_pkg;

    localparam int unsigned PALETTE_ENTRIES_DEF = 256;
    localparam int unsigned INDEX_W             = 8;
    localparam int unsigned QUEUE_DEPTH         = 4;
    localparam int unsigned QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_X       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_Y       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_W       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_H       = 3'd5;

    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd720;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd576;

    localparam logic KIND_PALETTE = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    localparam logic [17:0] LUMA_COEF_R = 18'd263;
    localparam logic [17:0] LUMA_COEF_G = 18'd516;
    localparam logic [17:0] LUMA_COEF_B = 18'd100;
    localparam logic [7:0]  LUMA_OFFSET = 8'd16;
    localparam logic [7:0]  ALPHA_MAX   = 8'hff;

    typedef struct packed {
        logic        kind;
        logic [7:0]  palette_slot;
        logic [31:0] palette_rgba;
        logic [7:0]  pixel_index;
        logic [7:0]  background_luma;
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
    } req_word_t;

    typedef struct packed {
        logic [7:0] blended_luma;
        logic       inside_clip;
    } rsp_word_t;

    // classified word handed from the front to the back
    typedef struct packed {
        logic        is_pixel;
        logic        in_range;
        logic [7:0]  addr;
        logic [7:0]  luma;
        logic [7:0]  alpha;
        logic [7:0]  bg;
        logic        clip_hit;
    } qword_t;

    typedef struct packed {
        logic [QUEUE_CNT_W-1:0] count;
        logic                   full;
        logic                   empty;
    } qstat_t;

endpackage
`default_nettype wire

/* src/pol_front.sv */
// Front end: configuration registers, input register, luma conversion and clip test.
`timescale 1ns / 1ps
`default_nettype none
module pol_front #(
    parameter int unsigned PALETTE_ENTRIES = pol_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire pol_pkg::req_word_t                 req_word,
    input  wire logic                               cfg_wr_en,
    input  wire logic [pol_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pol_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               q_full,
    output logic                                    q_push,
    output pol_pkg::qword_t                         q_push_word
);

    localparam logic [pol_pkg::INDEX_W:0] ENTRY_LIMIT = (pol_pkg::INDEX_W + 1)'(PALETTE_ENTRIES);

    logic [12:0] frame_width_reg;
    logic [12:0] frame_height_reg;
    logic [11:0] rect_x_reg;
    logic [11:0] rect_y_reg;
    logic [12:0] rect_w_reg;
    logic [12:0] rect_h_reg;

    logic            valid_reg;
    logic            valid_next;
    pol_pkg::qword_t word_reg;
    pol_pkg::qword_t word_next;

    logic        accept;
    logic [17:0] luma_sum;
    logic [7:0]  luma;
    logic [7:0]  sel_index;
    logic        x_ok;
    logic        y_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= pol_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= pol_pkg::FRAME_HEIGHT_RST;
            rect_x_reg       <= '0;
            rect_y_reg       <= '0;
            rect_w_reg       <= '0;
            rect_h_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pol_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                pol_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                pol_pkg::REG_RECT_X:       rect_x_reg       <= cfg_data[11:0];
                pol_pkg::REG_RECT_Y:       rect_y_reg       <= cfg_data[11:0];
                pol_pkg::REG_RECT_W:       rect_w_reg       <= cfg_data;
                pol_pkg::REG_RECT_H:       rect_h_reg       <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign req_stall = valid_reg && q_full;
    assign accept    = req_valid && !req_stall;
    assign q_push    = valid_reg && !q_full;
    assign q_push_word = word_reg;

    always_comb
    begin
        luma_sum = 18'(req_word.palette_rgba[7:0])   * pol_pkg::LUMA_COEF_R
                 + 18'(req_word.palette_rgba[15:8])  * pol_pkg::LUMA_COEF_G
                 + 18'(req_word.palette_rgba[23:16]) * pol_pkg::LUMA_COEF_B;
        luma = luma_sum[17:10] + pol_pkg::LUMA_OFFSET;

        // col < min(fw, rx+rw) - rx, origin past the frame fails the first compare
        x_ok = ((13'(req_word.pixel_col) + 13'(rect_x_reg)) < frame_width_reg)
            && (13'(req_word.pixel_col) < rect_w_reg);
        y_ok = ((13'(req_word.pixel_row) + 13'(rect_y_reg)) < frame_height_reg)
            && (13'(req_word.pixel_row) < rect_h_reg);

        sel_index = (req_word.kind == pol_pkg::KIND_PIXEL) ? req_word.pixel_index
                                                           : req_word.palette_slot;

        word_next.is_pixel = (req_word.kind == pol_pkg::KIND_PIXEL);
        word_next.in_range = ({1'b0, sel_index} < ENTRY_LIMIT);
        word_next.addr     = sel_index;
        word_next.luma     = luma;
        word_next.alpha    = req_word.palette_rgba[31:24];
        word_next.bg       = req_word.background_luma;
        word_next.clip_hit = x_ok && y_ok;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

endmodule
`default_nettype wire

/* src/pol_queue.sv */
// Short FIFO between the front end and the blend back end.
`timescale 1ns / 1ps
`default_nettype none
module pol_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire pol_pkg::qword_t  push_word,
    input  wire logic             pop,
    output pol_pkg::qword_t       pop_word,
    output pol_pkg::qstat_t       stat
);

    pol_pkg::qword_t                     slots [pol_pkg::QUEUE_DEPTH];
    logic [pol_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [pol_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [pol_pkg::QUEUE_CNT_W-1:0]     count_reg;
    logic [pol_pkg::QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [pol_pkg::QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [pol_pkg::QUEUE_CNT_W-1:0]     count_next;

    assign stat.count = count_reg;
    assign stat.full  = (count_reg == pol_pkg::QUEUE_CNT_W'(pol_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_word   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + pol_pkg::QUEUE_CNT_W'(push) - pol_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_word;
        end
    end

endmodule
`default_nettype wire

/* src/pol_back.sv */
// Back end: palette memory, alpha blend and output register.
`timescale 1ns / 1ps
`default_nettype none
module pol_back #(
    parameter int unsigned PALETTE_ENTRIES = pol_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pol_pkg::qword_t  q_word,
    input  wire pol_pkg::qstat_t  q_stat,
    output logic                  q_pop,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output pol_pkg::rsp_word_t    rsp_word
);

    localparam int unsigned ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [15:0] palette [PALETTE_ENTRIES];

    logic [15:0] rd_data_reg;
    logic        b1_valid_reg;
    logic        b1_valid_next;
    logic        b1_in_range_reg;
    logic        b1_clip_hit_reg;
    logic [7:0]  b1_bg_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    pol_pkg::rsp_word_t out_word_reg;
    pol_pkg::rsp_word_t out_word_next;

    logic              b1_advance;
    logic              b1_ready;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        pal_luma;
    logic [7:0]        pal_alpha;
    logic [15:0]       blend;

    assign b1_advance = b1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign b1_ready   = !b1_valid_reg || b1_advance;
    assign q_pop      = !q_stat.empty && b1_ready;
    assign addr       = q_word.addr[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (q_pop && !q_word.is_pixel && q_word.in_range)
        begin
            palette[addr] <= {q_word.alpha, q_word.luma};
        end
        if (q_pop && q_word.is_pixel)
        begin
            rd_data_reg     <= palette[addr];
            b1_in_range_reg <= q_word.in_range;
            b1_clip_hit_reg <= q_word.clip_hit;
            b1_bg_reg       <= q_word.bg;
        end
    end

    always_comb
    begin
        b1_valid_next = b1_valid_reg;
        if (q_pop)
        begin
            b1_valid_next = q_word.is_pixel;
        end
        else if (b1_advance)
        begin
            b1_valid_next = 1'b0;
        end
    end

    // index beyond the palette reads as luma 0, alpha 0
    always_comb
    begin
        pal_luma  = b1_in_range_reg ? rd_data_reg[7:0]  : 8'd0;
        pal_alpha = b1_in_range_reg ? rd_data_reg[15:8] : 8'd0;
        blend     = 16'(pal_luma) * 16'(pal_alpha)
                  + 16'(pol_pkg::ALPHA_MAX - pal_alpha) * 16'(b1_bg_reg);
        out_word_next.blended_luma = b1_clip_hit_reg ? blend[15:8] : b1_bg_reg;
        out_word_next.inside_clip  = b1_clip_hit_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (b1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b1_advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule
`default_nettype wire

/* src/palette_overlay_luma_blend.sv */
// Top level of the palette overlay luma blend.
// Usage:
//   req channel (req_valid/req_stall/req_word) takes one word per cycle while req_stall is low:
//   a palette write (kind 0) converts RGBA to luma and stores luma and alpha at palette_slot;
//   a pixel (kind 1) looks up pixel_index and blends it over background_luma.
//   rsp channel (rsp_valid/rsp_stall/rsp_word) returns one word per pixel, none per
//   palette write: blended luma, or the background when outside the clipped rectangle.
//   Config: cfg_wr_en/cfg_index/cfg_data write the frame and rectangle registers;
//   write only while the block is idle.
// Timing: an accepted pixel passes the input register, a queue slot and the palette
//   read register, then the output register loads and rsp_valid rises.
//   Throughput is one word per cycle while rsp is not stalled; each word makes one palette write or one read.
// Reset: control state clears, registers return to a 720x576 frame with an empty
//   rectangle; palette contents are undefined until written.
// Stall: a stalled rsp holds its word; the back end then stops, the queue fills and
//   req_stall rises once the input register cannot drain.
`timescale 1ns / 1ps
`default_nettype none
module palette_overlay_luma_blend #(
    parameter int unsigned PALETTE_ENTRIES = pol_pkg::PALETTE_ENTRIES_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire pol_pkg::req_word_t                 req_word,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output pol_pkg::rsp_word_t                      rsp_word,
    input  wire logic                               cfg_wr_en,
    input  wire logic [pol_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pol_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic            q_push;
    logic            q_pop;
    pol_pkg::qword_t q_push_word;
    pol_pkg::qword_t q_pop_word;
    pol_pkg::qstat_t q_stat;

    pol_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_word    (req_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_full      (q_stat.full),
        .q_push      (q_push),
        .q_push_word (q_push_word)
    );

    pol_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .pop       (q_pop),
        .pop_word  (q_pop_word),
        .stat      (q_stat)
    );

    pol_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_word    (q_pop_word),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("queue pushed while full");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (q_stat.count == $past(q_stat.count)
                  + pol_pkg::QUEUE_CNT_W'($past(q_push))
                  - pol_pkg::QUEUE_CNT_W'($past(q_pop))))
        else $error("queue occupancy does not follow push and pop");
`endif

endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench for palette_overlay_luma_blend: random and directed palette/pixel words checked against a local prediction.
`timescale 1ns / 1ps
module tb;
    import pol_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE      = 10;
    localparam int unsigned HOLD_LEN    = 300;
    localparam int unsigned SEG_ITEMS   = 238;
    localparam int unsigned PAL_DEPTH   = PALETTE_ENTRIES_DEF;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_stall;
    req_word_t              req_word = '0;
    logic                   rsp_valid;
    logic                   rsp_stall = 1'b0;
    rsp_word_t              rsp_word;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic                   hold_start = 1'b0;
    int unsigned            hold_left;
    int unsigned            send_idle_pct = 0;
    int unsigned            recv_stall_pct = 0;
    int unsigned            cycles = 0;
    int unsigned            errors = 0;
    int unsigned            palette_writes = 0;
    int unsigned            pixels_sent = 0;
    int unsigned            inside_hits = 0;
    int unsigned            results_checked = 0;
    int unsigned            settings_used = 0;

    logic [12:0]            cur_frame_w = FRAME_WIDTH_RST;
    logic [12:0]            cur_frame_h = FRAME_HEIGHT_RST;
    logic [11:0]            cur_rect_x = '0;
    logic [11:0]            cur_rect_y = '0;
    logic [12:0]            cur_rect_w = '0;
    logic [12:0]            cur_rect_h = '0;
    logic [15:0]            palette_mirror [PAL_DEPTH];

    req_word_t              send_fifo [$];
    rsp_word_t              due_lumas [$];
    bit                     slot_written [PAL_DEPTH];
    int unsigned            written_slots [$];

    palette_overlay_luma_blend dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string what);
        $display("ERROR at %0t: %s", $time, what);
        errors++;
    endtask

    function automatic void clip_dims(output int unsigned cw, output int unsigned ch);
        int unsigned fw, fh, rx, ry, ex, ey;
        fw = cur_frame_w;
        fh = cur_frame_h;
        rx = cur_rect_x;
        ry = cur_rect_y;
        cw = 0;
        ch = 0;
        if (rx <= fw && ry <= fh)
        begin
            ex = rx + cur_rect_w;
            ey = ry + cur_rect_h;
            cw = ((ex > fw) ? fw : ex) - rx;
            ch = ((ey > fh) ? fh : ey) - ry;
        end
    endfunction

    function automatic logic [7:0] rgba_luma(input logic [31:0] rgba);
        int unsigned sum;
        sum = LUMA_COEF_R * rgba[7:0] + LUMA_COEF_G * rgba[15:8] + LUMA_COEF_B * rgba[23:16];
        return 8'((sum >> 10) + LUMA_OFFSET);
    endfunction

    function automatic rsp_word_t blend_pixel(input req_word_t w);
        rsp_word_t   r;
        int unsigned cw, ch, y, a;
        clip_dims(cw, ch);
        r.inside_clip  = (w.pixel_col < cw) && (w.pixel_row < ch);
        r.blended_luma = w.background_luma;
        if (r.inside_clip)
        begin
            y = palette_mirror[w.pixel_index][7:0];
            a = palette_mirror[w.pixel_index][15:8];
            r.blended_luma = 8'((y * a + (ALPHA_MAX - a) * w.background_luma) >> 8);
        end
        return r;
    endfunction

    // update the palette mirror or queue the expected blend for one accepted word
    task automatic apply_overlay(input req_word_t w);
        rsp_word_t r;
        if (w.kind == KIND_PALETTE)
        begin
            palette_mirror[w.palette_slot] = {w.palette_rgba[31:24], rgba_luma(w.palette_rgba)};
            palette_writes++;
        end
        else
        begin
            r = blend_pixel(w);
            due_lumas.push_back(r);
            pixels_sent++;
            if (r.inside_clip)
                inside_hits++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        req_word_t nxt;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_word  <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                apply_overlay(req_word);
            if (!req_valid || !req_stall)
            begin
                if (send_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = send_fifo.pop_front();
                    req_valid <= 1'b1;
                    req_word  <= nxt;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver_hold
        if (!rst_n)
            hold_left <= 0;
        else if (hold_start)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_word_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d words still due", cycles, due_lumas.size());
                $display("Mismatches found");
                $finish;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (due_lumas.size() == 0)
                    report($sformatf("unexpected word luma %0d inside %0b",
                                     rsp_word.blended_luma, rsp_word.inside_clip));
                else
                begin
                    want = due_lumas.pop_front();
                    results_checked++;
                    if (rsp_word.blended_luma !== want.blended_luma)
                        report($sformatf("blended_luma %0d, want %0d",
                                         rsp_word.blended_luma, want.blended_luma));
                    if (rsp_word.inside_clip !== want.inside_clip)
                        report($sformatf("inside_clip %0b, want %0b",
                                         rsp_word.inside_clip, want.inside_clip));
                end
            end
            rsp_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    function automatic req_word_t noise_word();
        req_word_t w;
        w.kind            = KIND_PIXEL;
        w.palette_slot    = 8'($urandom_range(0, 255));
        w.palette_rgba    = $urandom;
        w.pixel_index     = 8'($urandom_range(0, 255));
        w.background_luma = 8'($urandom_range(0, 255));
        w.pixel_col       = 12'($urandom_range(0, 4095));
        w.pixel_row       = 12'($urandom_range(0, 4095));
        return w;
    endfunction

    task automatic push_palette(input int unsigned slot, input logic [31:0] rgba);
        req_word_t w;
        w = noise_word();
        w.kind         = KIND_PALETTE;
        w.palette_slot = 8'(slot);
        w.palette_rgba = rgba;
        if (!slot_written[slot])
        begin
            slot_written[slot] = 1'b1;
            written_slots.push_back(slot);
        end
        send_fifo.push_back(w);
    endtask

    task automatic push_pixel(input int unsigned idx, input int unsigned bg,
                              input int unsigned col, input int unsigned row);
        req_word_t w;
        w = noise_word();
        w.kind            = KIND_PIXEL;
        w.pixel_index     = 8'(idx);
        w.background_luma = 8'(bg);
        w.pixel_col       = 12'(col);
        w.pixel_row       = 12'(row);
        send_fifo.push_back(w);
    endtask

    task automatic wait_quiet();
        while (send_fifo.size() != 0 || req_valid || due_lumas.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  cur_frame_w = data;
            REG_FRAME_HEIGHT: cur_frame_h = data;
            REG_RECT_X:       cur_rect_x  = data[11:0];
            REG_RECT_Y:       cur_rect_y  = data[11:0];
            REG_RECT_W:       cur_rect_w  = data;
            REG_RECT_H:       cur_rect_h  = data;
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned fw, input int unsigned fh,
                                 input int unsigned rx, input int unsigned ry,
                                 input int unsigned rw, input int unsigned rh);
        wait_quiet();
        write_reg(REG_FRAME_WIDTH, 13'(fw));
        write_reg(REG_FRAME_HEIGHT, 13'(fh));
        write_reg(REG_RECT_X, 13'(rx));
        write_reg(REG_RECT_Y, 13'(ry));
        write_reg(REG_RECT_W, 13'(rw));
        write_reg(REG_RECT_H, 13'(rh));
        @(posedge clk);
        settings_used++;
    endtask

    task automatic random_setting();
        int unsigned fw, fh, rx, ry, rw, rh;
        fw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
        fh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
        rx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, fw - 1);
        ry = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, fh - 1);
        rw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 64);
        rh = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096) : $urandom_range(0, 64);
        apply_setting(fw, fh, rx, ry, rw, rh);
    endtask

    task automatic run_random(input int unsigned count, input bit with_hold);
        int unsigned cw, ch, col, row, idx;
        logic [31:0] rgba;
        clip_dims(cw, ch);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (written_slots.size() == 0 || $urandom_range(0, 3) == 0)
            begin
                rgba = $urandom;
                case ($urandom_range(0, 7))
                    0: rgba[31:24] = 8'h00;
                    1: rgba[31:24] = 8'hff;
                    default: ;
                endcase
                push_palette($urandom_range(0, PAL_DEPTH - 1), rgba);
            end
            else
            begin
                idx = written_slots[$urandom_range(0, written_slots.size() - 1)];
                if ($urandom_range(0, 4) == 0)
                begin
                    col = $urandom_range(0, 4095);
                    row = $urandom_range(0, 4095);
                end
                else
                begin
                    col = $urandom_range(0, (cw + 4 > 4095) ? 4095 : cw + 4);
                    row = $urandom_range(0, (ch + 4 > 4095) ? 4095 : ch + 4);
                end
                push_pixel(idx, $urandom_range(0, 255), col, row);
            end
        end
        if (with_hold)
        begin
            @(posedge clk);
            hold_start <= 1'b1;
            @(posedge clk);
            hold_start <= 1'b0;
        end
    endtask

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: empty rectangle, nothing inside
        push_palette(0, 32'h0000_0000);
        push_palette(255, 32'hffff_ffff);
        push_palette(1, 32'h8000_00ff);
        push_palette(2, 32'h0100_ff00);
        push_palette(3, 32'hfeff_0000);
        push_pixel(0, 255, 0, 0);
        wait_quiet();
        write_reg(REG_UNMAPPED_LO, 13'h1fff);
        write_reg(REG_UNMAPPED_HI, 13'h0000);

        // largest frame, rectangle covers all
        apply_setting(4096, 4096, 0, 0, 4096, 4096);
        push_pixel(255, 0, 0, 0);
        push_pixel(255, 255, 4095, 4095);
        push_pixel(0, 255, 4095, 0);
        push_pixel(1, 0, 100, 200);
        push_pixel(2, 255, 0, 4095);
        push_pixel(3, 128, 2048, 2048);

        // origin at the far corner, one pixel left
        apply_setting(4096, 4096, 4095, 4095, 4096, 4096);
        push_pixel(255, 7, 0, 0);
        push_pixel(255, 7, 1, 0);
        push_pixel(255, 7, 0, 1);

        // origin beyond the frame
        apply_setting(64, 48, 65, 10, 100, 100);
        push_pixel(255, 33, 0, 0);

        // origin on the frame edge, zero width
        apply_setting(64, 48, 64, 0, 10, 10);
        push_pixel(255, 44, 0, 0);

        // single pixel frame
        apply_setting(1, 1, 0, 0, 1, 1);
        push_pixel(1, 200, 0, 0);
        push_pixel(1, 200, 1, 0);

        // rectangle overhangs the frame
        apply_setting(300, 200, 250, 150, 4096, 4096);
        push_pixel(2, 90, 49, 49);
        push_pixel(2, 90, 50, 0);
        push_pixel(2, 90, 0, 50);

        // zero-width rectangle
        apply_setting(720, 576, 10, 10, 0, 300);
        push_pixel(3, 12, 0, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            wait_quiet();
            send_idle_pct  = (phase == 0) ? 10 : (phase == 1) ? 50 : 0;
            recv_stall_pct = (phase == 0) ? 50 : (phase == 1) ? 10 : 0;
            random_setting();
            run_random(SEG_ITEMS, phase == 2);
            random_setting();
            run_random(SEG_ITEMS, 1'b0);
        end

        wait_quiet();
        $display("Run covered %0d palette writes and %0d pixels (%0d inside the clip) over %0d settings",
                 palette_writes, pixels_sent, inside_hits, settings_used);
        $display("Checked %0d blended words under sender gaps, receiver stalls and a long hold-off",
                 results_checked);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
